FILE: rtl/core/rbc_pkg.sv
// Shared types, register codes and pixel packing for the rectangle blit core.
// No dependencies; imported by every module of the core.
package rbc_pkg;

  localparam int LINE_W     = 13;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int SUM_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 32;

  localparam logic [LINE_W-1:0] LINE_PIXELS_RESET = 13'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_PIXELS = 3'd0,
    REG_PIXEL_MODE  = 3'd1,
    REG_SRC_X       = 3'd2,
    REG_SRC_Y       = 3'd3,
    REG_DST_X       = 3'd4,
    REG_DST_Y       = 3'd5,
    REG_RECT_WIDTH  = 3'd6,
    REG_RECT_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [LINE_W-1:0]  line_pixels;
    logic               pixel_mode;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [DIM_W-1:0]   rect_width;
    logic [DIM_W-1:0]   rect_height;
  } cfg_t;

  // One pixel in flight between the walker and the address stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             mode;
    logic [SUM_W-1:0] src_row;
    logic [SUM_W-1:0] dst_row;
    logic [SUM_W-1:0] src_col;
    logic [SUM_W-1:0] dst_col;
    logic             last;
  } blit_item_t;

  // Truncate RGB888 to RGB565
  function automatic logic [15:0] pack565(input logic [PIX_W-1:0] p);
    return {p[23:19], p[15:10], p[7:3]};
  endfunction

endpackage

FILE: rtl/core/rbc_cfg.sv
// Configuration register file of the rectangle blit core.
// Depends on rbc_pkg for the register codes and the cfg_t layout.
module rbc_cfg import rbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Decode the write into the selected register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINE_PIXELS: cfg_nxt.line_pixels = cfg_data[LINE_W-1:0];
        REG_PIXEL_MODE:  cfg_nxt.pixel_mode  = cfg_data[0];
        REG_SRC_X:       cfg_nxt.src_x       = cfg_data[COORD_W-1:0];
        REG_SRC_Y:       cfg_nxt.src_y       = cfg_data[COORD_W-1:0];
        REG_DST_X:       cfg_nxt.dst_x       = cfg_data[COORD_W-1:0];
        REG_DST_Y:       cfg_nxt.dst_y       = cfg_data[COORD_W-1:0];
        REG_RECT_WIDTH:  cfg_nxt.rect_width  = cfg_data[DIM_W-1:0];
        REG_RECT_HEIGHT: cfg_nxt.rect_height = cfg_data[DIM_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{line_pixels: LINE_PIXELS_RESET, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/rbc_walk.sv
// Raster walker: column/row counters and the input register stage.
// Depends on rbc_pkg for cfg_t and blit_item_t.
module rbc_walk import rbc_pkg::*; #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int STRIDE_W        = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    in_src_pixel,
  input  logic                adv,
  output logic                item_valid,
  output blit_item_t          item,
  output logic [STRIDE_W-1:0] stride
);

  logic [DIM_W-1:0]    col_r, col_nxt;
  logic [DIM_W-1:0]    row_r, row_nxt;
  logic                item_valid_r, item_valid_nxt;
  blit_item_t          item_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [STRIDE_W-1:0] stride_nxt;
  logic                accept;
  logic                empty;
  logic                row_end;
  logic                last;

  assign in_ready   = !item_valid_r || adv;
  assign accept     = in_valid && in_ready;
  assign empty      = (cfg.rect_width == '0) || (cfg.rect_height == '0);
  assign item_valid = item_valid_r;
  assign item       = item_r;
  assign stride     = stride_r;

  // End-of-row and end-of-rectangle tests
  assign row_end = ({1'b0, col_r} + 14'd1) >= {1'b0, cfg.rect_width};
  assign last    = row_end && (({1'b0, row_r} + 14'd1) >= {1'b0, cfg.rect_height});

  // Saturate the row stride
  assign stride_nxt = (32'(cfg.line_pixels) > 32'(MAX_LINE_PIXELS)) ?
                      STRIDE_W'(MAX_LINE_PIXELS) : STRIDE_W'(cfg.line_pixels);

  // Advance the counters on each item that produces a write
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && !empty) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 13'd1;
      end else begin
        col_nxt = col_r + 13'd1;
      end
    end
  end

  // Stage holds an item until the address stage takes it; drop empty-rect items
  always_comb begin
    if (accept) begin
      item_valid_nxt = !empty;
    end else if (adv) begin
      item_valid_nxt = 1'b0;
    end else begin
      item_valid_nxt = item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      item_valid_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      item_valid_r <= item_valid_nxt;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.pixel   <= in_src_pixel;
      item_r.mode    <= cfg.pixel_mode;
      item_r.src_row <= {2'b00, cfg.src_y} + {1'b0, row_r};
      item_r.dst_row <= {2'b00, cfg.dst_y} + {1'b0, row_r};
      item_r.src_col <= {2'b00, cfg.src_x} + {1'b0, col_r};
      item_r.dst_col <= {2'b00, cfg.dst_x} + {1'b0, col_r};
      item_r.last    <= last;
      stride_r       <= stride_nxt;
    end
  end

endmodule

FILE: rtl/core/rbc_emit.sv
// Address and data stage: row*stride+col, RGB565 packing and result register.
// Depends on rbc_pkg for blit_item_t and pack565.
module rbc_emit import rbc_pkg::*; #(
  parameter int STRIDE_W    = 13,
  parameter int OFFSET_BITS = 27
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  input  blit_item_t             item,
  input  logic [STRIDE_W-1:0]    stride,
  output logic                   adv,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_BITS-1:0] out_src_offset,
  output logic [OFFSET_BITS-1:0] out_dst_offset,
  output logic [PIX_W-1:0]       out_dst_data,
  output logic                   out_half_word,
  output logic                   out_last_pixel
);

  localparam int PW = SUM_W + STRIDE_W;
  localparam int LW = (PW + 1 > OFFSET_BITS) ? PW + 1 : OFFSET_BITS;

  logic [PW-1:0]          src_prod, dst_prod;
  logic [LW-1:0]          src_lin, dst_lin;
  logic [OFFSET_BITS-1:0] src_off_nxt, dst_off_nxt;
  logic [PIX_W-1:0]       data_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OFFSET_BITS-1:0] src_off_r, dst_off_r;
  logic [PIX_W-1:0]       data_r;
  logic                   half_r, last_r;

  assign adv = !out_valid_r || out_ready;

  // Linear pixel index in each buffer
  assign src_prod = item.src_row * stride;
  assign dst_prod = item.dst_row * stride;
  assign src_lin  = LW'(src_prod) + LW'(item.src_col);
  assign dst_lin  = LW'(dst_prod) + LW'(item.dst_col);

  // Scale to bytes and wrap at the offset width
  assign src_off_nxt = OFFSET_BITS'({src_lin, 2'b00});
  assign dst_off_nxt = item.mode ? OFFSET_BITS'({dst_lin, 1'b0})
                                 : OFFSET_BITS'({dst_lin, 2'b00});
  assign data_nxt    = item.mode ? {16'h0000, pack565(item.pixel)} : item.pixel;

  // Hold the result until taken
  always_comb begin
    if (adv) begin
      out_valid_nxt = item_valid;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_valid) begin
      src_off_r <= src_off_nxt;
      dst_off_r <= dst_off_nxt;
      data_r    <= data_nxt;
      half_r    <= item.mode;
      last_r    <= item.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_src_offset = src_off_r;
  assign out_dst_offset = dst_off_r;
  assign out_dst_data   = data_r;
  assign out_half_word  = half_r;
  assign out_last_pixel = last_r;

endmodule

FILE: rtl/core/rect_blit_with_rgb565_convert_core.sv
// Rectangle blit engine: RGB888 source pixels to framebuffer writes.
// Pipeline: 2 register stages (walker, address) between input accept and out_valid.
// Throughput: 1 item per cycle while out_ready is high; one multiplier per buffer
// in the address stage. in_ready follows out_ready combinationally through the pipeline.
// Reset (synchronous, rst_n low): registers to defaults (line_pixels 640),
// counters to zero, pipeline emptied. Config port is always ready.
module rect_blit_with_rgb565_convert_core import rbc_pkg::*; #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int OFFSET_BITS     = 27
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIX_W-1:0]       in_src_pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFFSET_BITS-1:0] out_src_offset,
  output logic [OFFSET_BITS-1:0] out_dst_offset,
  output logic [PIX_W-1:0]       out_dst_data,
  output logic                   out_half_word,
  output logic                   out_last_pixel
);

  localparam int STRIDE_W = $clog2(MAX_LINE_PIXELS + 1);

  cfg_t                cfg;
  logic                adv;
  logic                item_valid;
  blit_item_t          item;
  logic [STRIDE_W-1:0] stride;

  rbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbc_walk #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
    .STRIDE_W        (STRIDE_W)
  ) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_src_pixel (in_src_pixel),
    .adv          (adv),
    .item_valid   (item_valid),
    .item         (item),
    .stride       (stride)
  );

  rbc_emit #(
    .STRIDE_W    (STRIDE_W),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item           (item),
    .stride         (stride),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_dst_data   (out_dst_data),
    .out_half_word  (out_half_word),
    .out_last_pixel (out_last_pixel)
  );

endmodule

FILE: rtl/core/rbc_check.sv
// Port-level checker for the rectangle blit core, bound to the top level.
// Depends on rbc_pkg for the pixel width.
module rbc_check import rbc_pkg::*; #(
  parameter int OFFSET_BITS = 27
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OFFSET_BITS-1:0] out_src_offset,
  input logic [OFFSET_BITS-1:0] out_dst_offset,
  input logic [PIX_W-1:0]       out_dst_data,
  input logic                   out_half_word,
  input logic                   out_last_pixel
);

  // Stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_src_offset) &&
      $stable(out_dst_offset) && $stable(out_dst_data) &&
      $stable(out_half_word) && $stable(out_last_pixel))
    else $error("result changed while stalled");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // Source offsets are word aligned
  a_src_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_src_offset[1:0] == 2'b00)
    else $error("unaligned source offset");

  // 16-bit writes: halfword aligned, upper data zero
  a_half_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_half_word |-> out_dst_offset[0] == 1'b0 &&
      out_dst_data[31:16] == 16'h0000)
    else $error("bad 16-bit write");

  // 32-bit writes are word aligned
  a_word_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_half_word |-> out_dst_offset[1:0] == 2'b00)
    else $error("unaligned 32-bit write");

endmodule

bind rect_blit_with_rgb565_convert_core rbc_check #(
  .OFFSET_BITS (OFFSET_BITS)
) u_rbc_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_src_offset (out_src_offset),
  .out_dst_offset (out_dst_offset),
  .out_dst_data   (out_dst_data),
  .out_half_word  (out_half_word),
  .out_last_pixel (out_last_pixel)
);

FILE: dv/tb_rect_blit_with_rgb565_convert_core.sv
// Self-checking testbench for the rectangle blit core with RGB565 packing.
// Directed stimulus table, then random rectangles, checked by a local model.
// Needs rbc_pkg and rect_blit_with_rgb565_convert_core.
`timescale 1ns / 100ps

module tb_rect_blit_with_rgb565_convert_core;
  import rbc_pkg::*;

  localparam int MAX_LINE     = 4096;
  localparam int RANDOM_ITEMS = 1650;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP    = 40;

  // One framebuffer write as the block reports it
  typedef struct packed {
    logic [26:0] src_off;
    logic [26:0] dst_off;
    logic [31:0] data;
    logic        half;
    logic        last;
  } blit_wr_t;

  typedef enum logic [1:0] {STEP_WRITE_REG, STEP_PIXEL, STEP_PIXEL_KNOWN} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    cfg_reg_t    idx;
    logic [12:0] val;
    logic [31:0] pix;
    blit_wr_t    wr;
  } plan_step_t;

  localparam blit_wr_t NO_WR = '0;
  localparam int PLAN_LEN = 30;

  // Directed table: register writes, pixels with typed writes, pixels left to the model
  plan_step_t plan [PLAN_LEN] = '{
    // empty rectangle right after reset
    '{STEP_PIXEL,       REG_LINE_PIXELS, 13'd0,    32'hFFFF_FFFF, NO_WR},
    '{STEP_WRITE_REG,   REG_RECT_WIDTH,  13'd1,    32'h0,         NO_WR},
    '{STEP_WRITE_REG,   REG_RECT_HEIGHT, 13'd1,    32'h0,         NO_WR},
    '{STEP_PIXEL_KNOWN, REG_LINE_PIXELS, 13'd0,    32'h1234_5678,
      '{27'd0, 27'd0, 32'h1234_5678, 1'b0, 1'b1}},
    '{STEP_PIXEL_KNOWN, REG_LINE_PIXELS, 13'd0,    32'hFFFF_FFFF,
      '{27'd0, 27'd0, 32'hFFFF_FFFF, 1'b0, 1'b1}},
    // RGB565 packing extremes
    '{STEP_WRITE_REG,   REG_PIXEL_MODE,  13'd1,    32'h0,         NO_WR},
    '{STEP_PIXEL_KNOWN, REG_LINE_PIXELS, 13'd0,    32'hFFFF_FFFF,
      '{27'd0, 27'd0, 32'h0000_FFFF, 1'b1, 1'b1}},
    '{STEP_PIXEL_KNOWN, REG_LINE_PIXELS, 13'd0,    32'h00F8_FCF8,
      '{27'd0, 27'd0, 32'h0000_FFFF, 1'b1, 1'b1}},
    '{STEP_PIXEL_KNOWN, REG_LINE_PIXELS, 13'd0,    32'hFF07_0307,
      '{27'd0, 27'd0, 32'h0000_0000, 1'b1, 1'b1}},
    '{STEP_PIXEL_KNOWN, REG_LINE_PIXELS, 13'd0,    32'h00FF_0000,
      '{27'd0, 27'd0, 32'h0000_F800, 1'b1, 1'b1}},
    '{STEP_WRITE_REG,   REG_SRC_X,       13'd1,    32'h0,         NO_WR},
    '{STEP_WRITE_REG,   REG_SRC_Y,       13'd1,    32'h0,         NO_WR},
    '{STEP_PIXEL_KNOWN, REG_LINE_PIXELS, 13'd0,    32'h0000_FC00,
      '{27'd2564, 27'd0, 32'h0000_07E0, 1'b1, 1'b1}},
    // zero stride with the far destination corner
    '{STEP_WRITE_REG,   REG_DST_X,       13'd4095, 32'h0,         NO_WR},
    '{STEP_WRITE_REG,   REG_DST_Y,       13'd4095, 32'h0,         NO_WR},
    '{STEP_WRITE_REG,   REG_LINE_PIXELS, 13'd0,    32'h0,         NO_WR},
    '{STEP_PIXEL_KNOWN, REG_LINE_PIXELS, 13'd0,    32'h0000_00F8,
      '{27'd4, 27'd8190, 32'h0000_001F, 1'b1, 1'b1}},
    // saturated stride, 3x2 rectangle cut short by a smaller height
    '{STEP_WRITE_REG,   REG_PIXEL_MODE,  13'd0,    32'h0,         NO_WR},
    '{STEP_WRITE_REG,   REG_LINE_PIXELS, 13'd8191, 32'h0,         NO_WR},
    '{STEP_WRITE_REG,   REG_RECT_WIDTH,  13'd3,    32'h0,         NO_WR},
    '{STEP_WRITE_REG,   REG_RECT_HEIGHT, 13'd2,    32'h0,         NO_WR},
    '{STEP_PIXEL,       REG_LINE_PIXELS, 13'd0,    32'h0102_0304, NO_WR},
    '{STEP_PIXEL,       REG_LINE_PIXELS, 13'd0,    32'hA5A5_5A5A, NO_WR},
    '{STEP_PIXEL,       REG_LINE_PIXELS, 13'd0,    32'h8000_0001, NO_WR},
    '{STEP_PIXEL,       REG_LINE_PIXELS, 13'd0,    32'h7FFF_FFFE, NO_WR},
    '{STEP_WRITE_REG,   REG_RECT_HEIGHT, 13'd1,    32'h0,         NO_WR},
    '{STEP_PIXEL,       REG_LINE_PIXELS, 13'd0,    32'hDEAD_BEEF, NO_WR},
    '{STEP_PIXEL,       REG_LINE_PIXELS, 13'd0,    32'h0F0F_F0F0, NO_WR},
    // zero width drops the pixel
    '{STEP_WRITE_REG,   REG_RECT_WIDTH,  13'd0,    32'h0,         NO_WR},
    '{STEP_PIXEL,       REG_LINE_PIXELS, 13'd0,    32'h5555_AAAA, NO_WR}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_LINE_PIXELS;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_src_pixel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [26:0] out_src_offset;
  logic [26:0] out_dst_offset;
  logic [31:0] out_dst_data;
  logic        out_half_word;
  logic        out_last_pixel;

  // Local copy of the registers and the rectangle walk position
  cfg_t        regs;
  logic [12:0] col_pos;
  logic [12:0] row_pos;

  blit_wr_t write_q [$];
  int       mismatches = 0;
  int       writes_seen = 0;
  bit       hold_ready = 1'b0;
  bit       steady_run = 1'b0;

  rect_blit_with_rgb565_convert_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_src_pixel   (in_src_pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_src_offset (out_src_offset),
    .out_dst_offset (out_dst_offset),
    .out_dst_data   (out_dst_data),
    .out_half_word  (out_half_word),
    .out_last_pixel (out_last_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit idle_now();
    return !steady_run && ($urandom_range(99) < 27);
  endfunction

  // Compute the write for one pixel and advance the walk position
  function automatic bit blit_step(input logic [31:0] pix, output blit_wr_t wr);
    logic [63:0] stride, s_lin, d_lin;
    logic        row_end, fin;
    wr = '0;
    if (regs.rect_width == '0 || regs.rect_height == '0) return 1'b0;
    stride = (int'(regs.line_pixels) > MAX_LINE) ? 64'(MAX_LINE) : 64'(regs.line_pixels);
    s_lin = (64'(regs.src_y) + 64'(row_pos)) * stride + 64'(regs.src_x) + 64'(col_pos);
    d_lin = (64'(regs.dst_y) + 64'(row_pos)) * stride + 64'(regs.dst_x) + 64'(col_pos);
    wr.src_off = 27'(s_lin * 4);
    if (regs.pixel_mode) begin
      wr.dst_off = 27'(d_lin * 2);
      wr.data    = {16'h0000, pix[23:19], pix[15:10], pix[7:3]};
      wr.half    = 1'b1;
    end else begin
      wr.dst_off = 27'(d_lin * 4);
      wr.data    = pix;
      wr.half    = 1'b0;
    end
    // a position already past a shrunken edge counts as the edge
    row_end = (14'(col_pos) + 14'd1) >= 14'(regs.rect_width);
    fin     = row_end && ((14'(row_pos) + 14'd1) >= 14'(regs.rect_height));
    wr.last = fin;
    if (fin) begin
      col_pos = '0;
      row_pos = '0;
    end else if (row_end) begin
      col_pos = '0;
      row_pos = row_pos + 13'd1;
    end else begin
      col_pos = col_pos + 13'd1;
    end
    return 1'b1;
  endfunction

  // Pixels still needed to close the current rectangle, capped
  function automatic int pixels_left();
    int c, r, n;
    c = col_pos;
    r = row_pos;
    if (regs.rect_width == '0 || regs.rect_height == '0) return 0;
    for (n = 1; n < 5000; n++) begin
      if (c + 1 >= regs.rect_width) begin
        if (r + 1 >= regs.rect_height) return n;
        c = 0;
        r++;
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  function automatic logic [12:0] pick_value(input cfg_reg_t idx);
    int roll;
    roll = $urandom_range(99);
    case (idx)
      REG_LINE_PIXELS: begin
        if (roll < 10) return 13'd0;
        if (roll < 20) return 13'd4096;
        if (roll < 30) return 13'($urandom_range(8191, 4097));
        if (roll < 38) return 13'd8191;
        if (roll < 70) return 13'($urandom_range(64, 1));
        return 13'($urandom);
      end
      REG_PIXEL_MODE: return 13'($urandom);
      REG_RECT_WIDTH, REG_RECT_HEIGHT: begin
        if (roll < 8) return 13'd0;
        if (roll < 11) return 13'd8191;
        if (roll < 13) return 13'd4096;
        if (roll < 18) return 13'($urandom);
        return 13'($urandom_range(8, 1));
      end
      default: begin
        if (roll < 15) return {1'($urandom), 12'h000};
        if (roll < 30) return {1'($urandom), 12'hFFF};
        return 13'($urandom);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_pixel();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 32'h0000_0000;
    if (roll < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("write %0d: %s got %h, expected %h", writes_seen, what, got, want);
  endtask

  // Write one register; leave cfg_valid high for the caller to drop
  task automatic write_reg(input cfg_reg_t idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LINE_PIXELS: regs.line_pixels = val;
      REG_PIXEL_MODE:  regs.pixel_mode  = val[0];
      REG_SRC_X:       regs.src_x       = val[11:0];
      REG_SRC_Y:       regs.src_y       = val[11:0];
      REG_DST_X:       regs.dst_x       = val[11:0];
      REG_DST_Y:       regs.dst_y       = val[11:0];
      REG_RECT_WIDTH:  regs.rect_width  = val;
      REG_RECT_HEIGHT: regs.rect_height = val;
      default: ;
    endcase
  endtask

  // Offer one pixel after a random gap; queue its write once accepted
  task automatic push_pixel(input logic [31:0] pix, input bit known,
                            input blit_wr_t typed, output bit made);
    blit_wr_t wr;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_pixel <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    made = blit_step(pix, wr);
    if (made) write_q.push_back(known ? typed : wr);
  endtask

  // Drop valid, wait for all writes, then let dropped pixels clear the pipe
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (write_q.size() != 0) @(posedge clk);
    hold_ready = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    hold_ready = 1'b0;
  endtask

  // Check each accepted write against the oldest pending one; drive out_ready
  always @(posedge clk) begin
    blit_wr_t want;
    if (rst_n && out_valid && out_ready) begin
      if (write_q.size() == 0) begin
        report_mismatch("write with nothing pending, data", out_dst_data, '0);
      end else begin
        want = write_q.pop_front();
        if (out_src_offset !== want.src_off)
          report_mismatch("src_offset", 32'(out_src_offset), 32'(want.src_off));
        if (out_dst_offset !== want.dst_off)
          report_mismatch("dst_offset", 32'(out_dst_offset), 32'(want.dst_off));
        if (out_dst_data !== want.data)
          report_mismatch("dst_data", out_dst_data, want.data);
        if (out_half_word !== want.half)
          report_mismatch("half_word", 32'(out_half_word), 32'(want.half));
        if (out_last_pixel !== want.last)
          report_mismatch("last_pixel", 32'(out_last_pixel), 32'(want.last));
      end
      writes_seen++;
    end
    out_ready <= hold_ready || !idle_now();
  end

  initial begin
    int         made_items, phase, left, n;
    bit         made;
    step_kind_t prev;
    made_items = 0;
    phase      = 0;
    prev       = STEP_PIXEL;
    regs       = '0;
    regs.line_pixels = LINE_PIXELS_RESET;
    col_pos    = '0;
    row_pos    = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE_REG) begin
        if (prev != STEP_WRITE_REG) wait_drained();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (prev == STEP_WRITE_REG) cfg_valid <= 1'b0;
        push_pixel(plan[i].pix, plan[i].kind == STEP_PIXEL_KNOWN, plan[i].wr, made);
      end
      prev = plan[i].kind;
    end

    // Random rectangles, mostly completed, some cut short by new registers
    while (made_items < RANDOM_ITEMS) begin
      wait_drained();
      steady_run = (phase >= 30 && phase < 60);
      for (int r = 0; r < 8; r++) begin
        if (phase == 0 || $urandom_range(99) < 35)
          write_reg(cfg_reg_t'(r), pick_value(cfg_reg_t'(r)));
      end
      cfg_valid <= 1'b0;
      left = pixels_left();
      if (left == 0)
        n = $urandom_range(3, 1);
      else if (left > 40 || $urandom_range(99) < 15)
        n = $urandom_range((left > 40) ? 40 : left, 1);
      else
        n = left;
      repeat (n) begin
        push_pixel(pick_pixel(), 1'b0, NO_WR, made);
        if (made) made_items++;
      end
      phase++;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("rect_blit_with_rgb565_convert_core verification clean");
    end else begin
      $display("rect_blit_with_rgb565_convert_core verification failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(5_000_000);
    $display("rect_blit_with_rgb565_convert_core verification failed");
    $finish;
  end

endmodule
